// ===== src/rgb2hsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb2hsl_pkg
// shared types and widths for the rgb to hsl pixel pipeline
// ----------------------------------------------------------------------------
package rgb2hsl_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned SUM_W     = CHAN_W + 1;
  localparam int unsigned HUE6_W    = 11;
  localparam int unsigned SAT_REM_W = 16;
  localparam int unsigned HUE_REM_W = 19;
  localparam int unsigned Q_W       = 8;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // divider payload, one restoring step per stage
  typedef struct packed {
    logic [HUE_REM_W-1:0] hue_rem;
    logic [HUE6_W-1:0]    hue_den;
    logic [SAT_REM_W-1:0] sat_rem;
    logic [SUM_W-1:0]     sat_den;
    logic [Q_W-1:0]       hue_q;
    logic [Q_W-1:0]       sat_q;
    logic [CHAN_W-1:0]    lightness;
  } div_t;

endpackage

// ===== src/rgb2hsl_front.sv =====
// ----------------------------------------------------------------------------
// rgb2hsl_front
// three register stages: channel extremes, hue sector and saturation
// divisor, then scaling of the numerators by 255 and of the hue divisor by 6
// ----------------------------------------------------------------------------
module rgb2hsl_front
  import rgb2hsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  output logic              out_valid,
  input  logic              out_ready,
  output div_t              out_data
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // stage 1 registers
  logic [CHAN_W-1:0] mx, mn;
  logic signed [CHAN_W:0] hdiff;
  sector_t sector;

  // stage 2 registers
  logic [CHAN_W-1:0] d;
  logic [CHAN_W-1:0] light;
  logic [SUM_W-1:0]  sat_den;
  logic [HUE6_W-1:0] h6;
  logic              gray;

  // stage 3 register
  div_t div_reg;

  // stage 1 next values
  logic [CHAN_W-1:0] mx_next, mn_next;
  logic signed [CHAN_W:0] hdiff_next;
  sector_t sector_next;

  // stage 2 next values
  logic [CHAN_W-1:0] d_next;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sat_den_next;
  logic [HUE6_W:0]   d_w, hdiff_w, h6_w;

  // stage 3 next value
  div_t div_next;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    mx_next = red;
    mn_next = red;
    if (green > mx_next) mx_next = green;
    if (blue > mx_next)  mx_next = blue;
    if (green < mn_next) mn_next = green;
    if (blue < mn_next)  mn_next = blue;
    if (red == mx_next) begin
      sector_next = SEC_RED;
      hdiff_next  = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green == mx_next) begin
      sector_next = SEC_GREEN;
      hdiff_next  = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sector_next = SEC_BLUE;
      hdiff_next  = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  always_comb begin
    d_next  = mx - mn;
    sum     = {1'b0, mx} + {1'b0, mn};
    d_w     = {{(HUE6_W+1-CHAN_W){1'b0}}, d_next};
    hdiff_w = {{(HUE6_W-CHAN_W){hdiff[CHAN_W]}}, hdiff};
    case (sector)
      SEC_RED: begin
        if (hdiff[CHAN_W]) h6_w = (d_w << 2) + (d_w << 1) + hdiff_w;
        else               h6_w = hdiff_w;
      end
      SEC_GREEN: h6_w = (d_w << 1) + hdiff_w;
      SEC_BLUE:  h6_w = (d_w << 2) + hdiff_w;
      default:   h6_w = '0;
    endcase
    if (d_next == '0)      sat_den_next = SUM_W'(1);
    else if (sum < 9'd255) sat_den_next = sum;
    else                   sat_den_next = 9'(10'd510 - {1'b0, sum});
  end

  always_comb begin
    div_next.sat_rem   = {d, 8'b0} - {8'b0, d};
    div_next.hue_rem   = {h6, 8'b0} - {8'b0, h6};
    div_next.hue_den   = gray ? HUE6_W'(1) : ({1'b0, d, 2'b0} + {2'b0, d, 1'b0});
    div_next.sat_den   = sat_den;
    div_next.hue_q     = '0;
    div_next.sat_q     = '0;
    div_next.lightness = light;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mx     <= mx_next;
      mn     <= mn_next;
      hdiff  <= hdiff_next;
      sector <= sector_next;
    end
    if (rdy2) begin
      d       <= d_next;
      light   <= sum[SUM_W-1:1];
      sat_den <= sat_den_next;
      h6      <= (d_next == '0) ? '0 : h6_w[HUE6_W-1:0];
      gray    <= (d_next == '0);
    end
    if (rdy3) begin
      div_reg <= div_next;
    end
  end

  assign out_valid = v3;
  assign out_data  = div_reg;

endmodule

// ===== src/rgb2hsl_div_stage.sv =====
// ----------------------------------------------------------------------------
// rgb2hsl_div_stage
// one restoring division step for hue and saturation side by side
// ----------------------------------------------------------------------------
module rgb2hsl_div_stage
  import rgb2hsl_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  logic valid;
  div_t data;
  div_t data_next;
  logic [HUE_REM_W-1:0] hue_trial;
  logic [SAT_REM_W-1:0] sat_trial;

  assign in_ready = !valid || out_ready;

  always_comb begin
    hue_trial = HUE_REM_W'(in_data.hue_den) << BIT;
    sat_trial = SAT_REM_W'(in_data.sat_den) << BIT;
    data_next = in_data;
    if (in_data.hue_rem >= hue_trial) begin
      data_next.hue_rem    = in_data.hue_rem - hue_trial;
      data_next.hue_q[BIT] = 1'b1;
    end
    if (in_data.sat_rem >= sat_trial) begin
      data_next.sat_rem    = in_data.sat_rem - sat_trial;
      data_next.sat_q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) data <= data_next;
  end

  assign out_valid = valid;
  assign out_data  = data;

  // partial remainder stays below the divisor at this weight
  a_hue_rem : assert property (@(posedge clk) disable iff (rst)
    valid |-> data.hue_rem < (HUE_REM_W'(data.hue_den) << BIT))
    else $error("hue remainder out of range");

  a_sat_rem : assert property (@(posedge clk) disable iff (rst)
    valid |-> data.sat_rem < (SAT_REM_W'(data.sat_den) << BIT))
    else $error("saturation remainder out of range");

endmodule

// ===== src/rgb_to_hsl_pixel_core.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_core
// 8-bit rgb pixel to 8-bit hue, saturation and lightness, streaming
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the pipeline is full, and returns one hsl
// result per pixel, in order. Each pixel passes three front stages (extremes,
// hue sector and divisor, scaling by 255) followed by eight restoring divider
// stages, one quotient bit each, shared by hue and saturation. Every stage
// holds its own valid bit, so bubbles close up under backpressure and the
// input keeps taking requests until the whole pipeline is full.
module rgb_to_hsl_pixel_core
  import rgb2hsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red, green, blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // hue, saturation, lightness
);

  logic [Q_W:0] valid_chain;
  logic [Q_W:0] ready_chain;
  div_t         data_chain [Q_W+1];

  rgb2hsl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .red       (s_axis_tdata[7:0]),
    .green     (s_axis_tdata[15:8]),
    .blue      (s_axis_tdata[23:16]),
    .out_valid (valid_chain[0]),
    .out_ready (ready_chain[0]),
    .out_data  (data_chain[0])
  );

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    rgb2hsl_div_stage #(
      .BIT (Q_W - 1 - i)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_chain[i]),
      .in_ready  (ready_chain[i]),
      .in_data   (data_chain[i]),
      .out_valid (valid_chain[i+1]),
      .out_ready (ready_chain[i+1]),
      .out_data  (data_chain[i+1])
    );
  end

  assign m_axis_tvalid  = valid_chain[Q_W];
  assign ready_chain[Q_W] = m_axis_tready;
  assign m_axis_tdata   = {data_chain[Q_W].lightness, data_chain[Q_W].sat_q,
                           data_chain[Q_W].hue_q};

  // input only blocks when the whole pipe is full behind a waiting result
  a_stall_src : assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a waiting result stays until it is taken
  a_chain_order : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("waiting result dropped");

endmodule

// ===== tb/rgb_to_hsl_pixel_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_checker
// watches both streams of the hsl core, predicts each result and compares
// ----------------------------------------------------------------------------
// Every accepted request is converted here to hue, saturation and lightness
// and queued. Every accepted result is compared field by field with the
// oldest queued prediction. A result with nothing queued and a wrong field
// both count as failures; the queue depth is handed out so that the test
// can see predictions left over at the end.
module rgb_to_hsl_pixel_checker
  import rgb2hsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red, green, blue
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // hue, saturation, lightness
  output int          fail_count,
  output int          pending_count,
  output int          checked_count
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [CHAN_W-1:0] lightness;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] hue;
  } hsl_t;

  typedef struct {
    rgb_t pixel;
    hsl_t hsl;
  } hsl_prediction_t;

  hsl_prediction_t hsl_expected[$];
  int              fails;
  int              checked;

  function automatic logic [CHAN_W-1:0] clamp_quot(int unsigned num, int unsigned den);
    int unsigned q;
    if (den == 0) begin
      return '0;
    end
    q = num / den;
    return (q > 255) ? 8'd255 : q[CHAN_W-1:0];
  endfunction

  function automatic hsl_t convert_pixel(rgb_t px);
    logic [CHAN_W-1:0] hi;
    logic [CHAN_W-1:0] lo;
    logic [CHAN_W-1:0] span;
    logic [SUM_W-1:0]  total;
    logic [HUE6_W-1:0] sixths;
    sector_t           sector;
    hsl_t              res;
    hi = px.red;
    lo = px.red;
    if (px.green > hi) hi = px.green;
    if (px.blue > hi) hi = px.blue;
    if (px.green < lo) lo = px.green;
    if (px.blue < lo) lo = px.blue;
    total = hi + lo;
    span = hi - lo;
    res.lightness = total[SUM_W-1:1];
    res.hue = '0;
    res.saturation = '0;
    // gray pixel keeps hue and saturation at zero
    if (span != 0) begin
      if (total < 255) begin
        res.saturation = clamp_quot(255 * span, total);
      end else begin
        res.saturation = clamp_quot(255 * span, 510 - total);
      end
      // ties for the maximum go to red, then green
      if (px.red == hi) begin
        sector = SEC_RED;
      end else if (px.green == hi) begin
        sector = SEC_GREEN;
      end else begin
        sector = SEC_BLUE;
      end
      case (sector)
        SEC_RED: begin
          sixths = HUE6_W'((px.green >= px.blue) ? px.green - px.blue
                                                 : 6 * span - (px.blue - px.green));
        end
        SEC_GREEN: begin
          sixths = HUE6_W'(2 * span + px.blue - px.red);
        end
        default: begin
          sixths = HUE6_W'(4 * span + px.red - px.green);
        end
      endcase
      res.hue = clamp_quot(255 * sixths, 6 * span);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    hsl_prediction_t oldest;
    hsl_t            got;
    if (rst) begin
      hsl_expected.delete();
      fails = 0;
      checked = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (hsl_expected.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT) begin
            $display("unexpected result h=%0d s=%0d l=%0d at %0t",
                     got.hue, got.saturation, got.lightness, $realtime);
          end
        end else begin
          oldest = hsl_expected.pop_front();
          checked++;
          if (got.hue !== oldest.hsl.hue || got.saturation !== oldest.hsl.saturation ||
              got.lightness !== oldest.hsl.lightness) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
              $display({"mismatch rgb=(%0d,%0d,%0d): expected h=%0d s=%0d l=%0d,",
                        " got h=%0d s=%0d l=%0d"},
                       oldest.pixel.red, oldest.pixel.green, oldest.pixel.blue,
                       oldest.hsl.hue, oldest.hsl.saturation, oldest.hsl.lightness,
                       got.hue, got.saturation, got.lightness);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        oldest.pixel = s_axis_tdata;
        oldest.hsl = convert_pixel(oldest.pixel);
        hsl_expected.push_back(oldest);
      end
    end
    fail_count <= fails;
    checked_count <= checked;
    pending_count <= hsl_expected.size();
  end

endmodule

// ===== tb/rgb_to_hsl_pixel_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_core_test
// stimulus and verdict for the rgb to hsl pixel core
// ----------------------------------------------------------------------------
// Sends corner-case pixels (extremes, gray, ties for the maximum, hue wrap
// and the saturation divisor boundary), then random pixels weighted towards
// gray and tied ones. Both stream sides idle at random with quiet phases in
// between, and the result side holds off once for long enough to fill the
// pipeline. A separate checker predicts and compares every result.
module rgb_to_hsl_pixel_core_test;

  import rgb2hsl_pkg::*;

  localparam int RANDOM_PIXELS = 1330;
  localparam int PHASE_LEN     = 100;
  localparam int HOLD_AT       = 500;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 30;
  localparam int CYCLE_LIMIT   = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // red, green, blue
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // hue, saturation, lightness

  int          fail_count;
  int          pending_count;
  int          checked_count;
  int          cycle_count;
  int          sent_count;
  int          gray_or_tied;
  bit          sender_quiet;
  bit          receiver_quiet;

  always #5 clk = ~clk;

  rgb_to_hsl_pixel_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rgb_to_hsl_pixel_checker hsl_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  function automatic int unsigned idle_cycles(bit quiet);
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  // one request, held until taken
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned gap;
    gap = idle_cycles(sender_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, g, r};
    do @(posedge clk); while (!s_axis_tready);
    sent_count++;
    if (r == g || g == b || r == b) gray_or_tied++;
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // result side, with one long hold-off
  initial begin
    int unsigned stall;
    int          taken;
    taken = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % PHASE_LEN == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AT) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = idle_cycles(receiver_quiet);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      taken++;
    end
  end

  initial begin
    logic [7:0] r, g, b, top, other;
    sent_count = 0;
    gray_or_tied = 0;
    sender_quiet = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // corner cases
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd100, 8'd50,  8'd75);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd254, 8'd255, 8'd254);
    send_pixel(8'd254, 8'd0,   8'd0);
    send_pixel(8'd200, 8'd100, 8'd54);
    send_pixel(8'd200, 8'd100, 8'd55);
    send_pixel(8'd10,  8'd200, 8'd100);
    send_pixel(8'd10,  8'd20,  8'd200);
    send_pixel(8'd170, 8'd85,  8'd170);
    send_pixel(8'd127, 8'd127, 8'd128);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % PHASE_LEN == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
        0: begin
          g = r;
          b = r;
        end
        1: begin
          // two channels share the maximum
          top = 8'($urandom_range(0, 255));
          other = 8'($urandom_range(0, top));
          case ($urandom_range(0, 2))
            0: begin r = top; g = top; b = other; end
            1: begin r = other; g = top; b = top; end
            default: begin r = top; g = other; b = top; end
          endcase
        end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d pixels, %0d of them gray or with tied channels", sent_count,
             gray_or_tied);
    $display("checked %0d results across random stalls and a %0d cycle output hold",
             checked_count, HOLD_CYCLES);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
